FILE: hw/rtl/tog_pkg.sv
`default_nettype none

package tog_pkg;

  // Register and position widths fixed by the register map
  localparam int CFG_W = 7;
  localparam int POS_W = 6;
  localparam int CFG_IDX_W = 2;

  // Largest tile edge and tile row count
  localparam logic [CFG_W-1:0] SIZE_MAX = CFG_W'(64);

  // Default line store depth
  localparam int MAX_TILES_ACROSS_DEF = 64;

  // Register reset values
  localparam logic [CFG_W-1:0] TILE_SIZE_RST    = CFG_W'(30);
  localparam logic [CFG_W-1:0] TILES_ACROSS_RST = CFG_W'(32);
  localparam logic [CFG_W-1:0] TILES_DOWN_RST   = CFG_W'(32);
  localparam logic [CFG_W-1:0] CORNER_SIZE_RST  = CFG_W'(3);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_SIZE,
    REG_TILES_ACROSS,
    REG_TILES_DOWN,
    REG_CORNER_SIZE
  } cfg_reg_e;

  // Register file contents
  typedef struct packed {
    logic [CFG_W-1:0] tile_size;
    logic [CFG_W-1:0] tiles_across;
    logic [CFG_W-1:0] tiles_down;
    logic [CFG_W-1:0] corner_size;
  } cfg_t;

  // Per-pixel tile position status from the raster counters
  typedef struct packed {
    logic             first;     // first pixel of the tile
    logic             tile_end;  // last pixel of the tile
    logic             grid_end;  // last tile of the image
    logic             masked;    // tile lies in a corner square
    logic [POS_W-1:0] row;
  } tile_info_t;

  // Map 0 to 1 and cap at the largest size
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > SIZE_MAX) begin
      r = SIZE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tile_occupancy_grid.sv
`default_nettype none

// Channel   Direction  Handshake                      Payload
// pixel     in         pixel_valid_i / pixel_ready_o  pixel_set_i
// tile      out        tile_valid_o / tile_ready_i    tile_flag_o, tile_col_o, tile_row_o,
//                                                     grid_end_o
// config    in         cfg_we_i (no wait)             cfg_idx_i, cfg_data_i
//
// One pixel per cycle unless a stalled tile output holds the work stage. A pixel
// is registered with its line store read, and its tile result is loaded into the
// output register when the work stage moves on.
// The line store read-modify-write is covered by a write-to-read bypass.
// Reset zeroes the raster position and line store valid bits, loads register defaults.
// A stalled tile output holds only the pixel that ends the next tile.

module tile_occupancy_grid import tog_pkg::*; #(
  parameter int MaxTilesAcross = MAX_TILES_ACROSS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 pixel_valid_i,
  output logic                      pixel_ready_o,
  input  wire logic                 pixel_set_i,
  output logic                      tile_valid_o,
  input  wire logic                 tile_ready_i,
  output logic                      tile_flag_o,
  output logic [POS_W-1:0]          tile_col_o,
  output logic [POS_W-1:0]          tile_row_o,
  output logic                      grid_end_o
);

  localparam int ColW = (MaxTilesAcross > 1) ? $clog2(MaxTilesAcross) : 1;

  cfg_t             cfg_q;
  logic [ColW-1:0]  col;
  tile_info_t       info;
  logic             accept;

  logic             s1_valid_q;
  logic             s1_pix_q;
  logic [ColW-1:0]  s1_col_q;
  tile_info_t       s1_info_q;
  logic             s1_move;
  logic [1:0]       rd_data;
  logic [1:0]       seen;

  logic             out_valid_q;
  logic             out_flag_q;
  logic [POS_W-1:0] out_col_q;
  logic [POS_W-1:0] out_row_q;
  logic             out_end_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_size    <= TILE_SIZE_RST;
      cfg_q.tiles_across <= TILES_ACROSS_RST;
      cfg_q.tiles_down   <= TILES_DOWN_RST;
      cfg_q.corner_size  <= CORNER_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TILE_SIZE:    cfg_q.tile_size    <= cfg_data_i;
        REG_TILES_ACROSS: cfg_q.tiles_across <= cfg_data_i;
        REG_TILES_DOWN:   cfg_q.tiles_down   <= cfg_data_i;
        REG_CORNER_SIZE:  cfg_q.corner_size  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the work stage stalls only on a tile result facing a full output
  assign s1_move       = s1_valid_q && (!s1_info_q.tile_end || !out_valid_q || tile_ready_i);
  assign pixel_ready_o = !s1_valid_q || s1_move;
  assign accept        = pixel_valid_i && pixel_ready_o;

  tog_raster #(
    .MaxTilesAcross(MaxTilesAcross),
    .ColW          (ColW)
  ) u_raster (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .adv_i (accept),
    .col_o (col),
    .info_o(info)
  );

  tog_line_store #(
    .Depth(MaxTilesAcross),
    .AddrW(ColW)
  ) u_line_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(col),
    .wr_en_i  (s1_move),
    .wr_addr_i(s1_col_q),
    .wr_data_i(seen),
    .rd_data_o(rd_data)
  );

  // Work stage: hold the accepted pixel with its position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_set_i;
      s1_col_q  <= col;
      s1_info_q <= info;
    end
  end

  // Merge the pixel into the seen values; a tile's first pixel starts fresh
  assign seen = (s1_info_q.first ? 2'b00 : rd_data) | (s1_pix_q ? 2'b10 : 2'b01);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && s1_info_q.tile_end) begin
      out_valid_q <= 1'b1;
    end else if (tile_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_info_q.tile_end) begin
      out_flag_q <= (seen == 2'b11) && !s1_info_q.masked;
      out_col_q  <= POS_W'(s1_col_q);
      out_row_q  <= s1_info_q.row;
      out_end_q  <= s1_info_q.grid_end;
    end
  end

  assign tile_valid_o = out_valid_q;
  assign tile_flag_o  = out_flag_q;
  assign tile_col_o   = out_col_q;
  assign tile_row_o   = out_row_q;
  assign grid_end_o   = out_end_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tog_raster.sv
`default_nettype none

module tog_raster import tog_pkg::*; #(
  parameter int MaxTilesAcross = MAX_TILES_ACROSS_DEF,
  parameter int ColW = 6
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire logic            adv_i,
  output logic [ColW-1:0]      col_o,
  output tile_info_t           info_o
);

  localparam int CmpW = (ColW + 1 > 8) ? ColW + 1 : 8;
  localparam int RowCmpW = CFG_W + 1;

  logic [POS_W-1:0] pix_q, pix_d;
  logic [POS_W-1:0] line_q, line_d;
  logic [POS_W-1:0] row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;

  logic [CFG_W-1:0] ts, h;
  logic [CmpW-1:0]  w, ta_ext, col_ext, cs_col;
  logic [RowCmpW-1:0] row_ext, cs_row, h_ext;
  logic px_last, line_last, col_last, row_last;
  logic col_band, row_band;

  // Clamp the configured sizes
  always_comb begin
    ts = clamp_size(cfg_i.tile_size);
    h  = clamp_size(cfg_i.tiles_down);
    ta_ext = CmpW'(cfg_i.tiles_across);
    if (ta_ext == '0) begin
      w = CmpW'(1);
    end else if (ta_ext > CmpW'(MaxTilesAcross)) begin
      w = CmpW'(MaxTilesAcross);
    end else begin
      w = ta_ext;
    end
  end

  // Last-position flags; a counter at or past its limit counts as last
  assign col_ext   = CmpW'(col_q);
  assign px_last   = (CFG_W'(pix_q) + CFG_W'(1)) >= ts;
  assign line_last = (CFG_W'(line_q) + CFG_W'(1)) >= ts;
  assign row_last  = (CFG_W'(row_q) + CFG_W'(1)) >= h;
  assign col_last  = (col_ext + CmpW'(1)) >= w;

  // Corner squares along each axis
  assign cs_col   = CmpW'(cfg_i.corner_size);
  assign row_ext  = RowCmpW'(row_q);
  assign cs_row   = RowCmpW'(cfg_i.corner_size);
  assign h_ext    = RowCmpW'(h);
  assign col_band = (col_ext < cs_col) || ((col_ext + cs_col) >= w);
  assign row_band = (row_ext < cs_row) || ((row_ext + cs_row) >= h_ext);

  // Advance the raster position, pixel then column then line then row
  always_comb begin
    pix_d  = pix_q;
    col_d  = col_q;
    line_d = line_q;
    row_d  = row_q;
    if (!px_last) begin
      pix_d = pix_q + POS_W'(1);
    end else begin
      pix_d = '0;
      if (!col_last) begin
        col_d = col_q + ColW'(1);
      end else begin
        col_d = '0;
        if (!line_last) begin
          line_d = line_q + POS_W'(1);
        end else begin
          line_d = '0;
          row_d  = row_last ? '0 : row_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q  <= '0;
      col_q  <= '0;
      line_q <= '0;
      row_q  <= '0;
    end else if (adv_i) begin
      pix_q  <= pix_d;
      col_q  <= col_d;
      line_q <= line_d;
      row_q  <= row_d;
    end
  end

  assign col_o            = col_q;
  assign info_o.first     = (pix_q == '0) && (line_q == '0);
  assign info_o.tile_end  = px_last && line_last;
  assign info_o.grid_end  = col_last && row_last;
  assign info_o.masked    = col_band && row_band;
  assign info_o.row       = row_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tog_line_store.sv
`default_nettype none

module tog_line_store import tog_pkg::*; #(
  parameter int Depth = MAX_TILES_ACROSS_DEF,
  parameter int AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [1:0]       wr_data_i,
  output logic [1:0]            rd_data_o
);

  logic [1:0]       mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [1:0]       mem_rd_q;
  logic             vld_rd_q;
  logic             byp_q;
  logic [1:0]       byp_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mem_rd_q <= mem[rd_addr_i];
    end
  end

  // Entries read as zero until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Capture valid and forward a write to the same entry in the same cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      vld_rd_q   <= valid_q[rd_addr_i];
      byp_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      byp_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : (vld_rd_q ? mem_rd_q : 2'b00);

endmodule

`default_nettype wire

FILE: hw/rtl/tog_checker.sv
`default_nettype none

module tog_checker import tog_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             pixel_ready_o,
  input wire logic             tile_valid_o,
  input wire logic             tile_ready_i,
  input wire logic             tile_flag_o,
  input wire logic [POS_W-1:0] tile_col_o,
  input wire logic [POS_W-1:0] tile_row_o,
  input wire logic             grid_end_o
);

  // A stalled tile item keeps its contents
  a_tile_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tile_valid_o && !tile_ready_i |=> tile_valid_o && $stable(tile_flag_o) &&
      $stable(tile_col_o) && $stable(tile_row_o) && $stable(grid_end_o))
    else $error("tile item changed while stalled");

  // Pixel input backs up only behind a stalled tile output
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pixel_ready_o |-> tile_valid_o && !tile_ready_i)
    else $error("pixel input blocked without output stall");

  // The tile after the end of the grid is the top-left tile
  a_grid_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tile_valid_o && tile_ready_i && grid_end_o |=>
      !tile_valid_o || (tile_col_o == '0 && tile_row_o == '0))
    else $error("grid did not restart at the top-left tile");

endmodule

bind tile_occupancy_grid tog_checker u_checker (.*);

`default_nettype wire
